FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while out of reset.
`define TMR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define TMR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/tmr_pkg.sv
// Types and constants of the triple interval timer.
package tmr_pkg;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 6;
  localparam int DATA_W  = 32;
  localparam int IRQ_W   = 3;
  localparam int PSC_W   = 16;
  localparam int CLK_W   = 5;
  localparam int CTL_W   = 6;
  localparam int STS_W   = 6;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  localparam int GRP_CLK_CTL  = 0;
  localparam int GRP_CNT_CTL  = 1;
  localparam int GRP_COUNT    = 2;
  localparam int GRP_INTERVAL = 3;
  localparam int GRP_MATCH0   = 4;
  localparam int NUM_MATCH    = 3;
  localparam int GRP_STATUS   = 7;
  localparam int GRP_IRQ_EN   = 8;
  localparam int NUM_DEC_GRP  = 9;

  localparam logic [CTL_W-1:0] CTL_RESET_VALUE = 6'h21;
  localparam logic [CTL_W-1:0] CTL_STORE_MASK  = 6'h2f;
  localparam int CTL_DIS_BIT    = 0;
  localparam int CTL_INT_BIT    = 1;
  localparam int CTL_STROBE_BIT = 4;
  localparam int CLK_PSC_EN_BIT = 0;
  localparam int STS_INT_BIT    = 0;
  localparam int STS_OVF_BIT    = 4;

  typedef struct packed {
    logic                   tick;
    logic                   rd;
    logic                   wr;
    logic [NUM_DEC_GRP-1:0] grp;
  } tmr_req_t;

endpackage

FILE: rtl/tmr_if.sv
// Valid/ready channel interfaces for the timer's item and result streams.
interface tmr_in_if;
  import tmr_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [IDX_W-1:0]  word_index;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output op, output word_index, output write_data,
                  input ready);
  modport sink   (input valid, input op, input word_index, input write_data,
                  output ready);
endinterface

interface tmr_out_if;
  import tmr_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [IRQ_W-1:0]  irq_lines;

  modport source (output valid, output read_data, output irq_lines, input ready);
  modport sink   (input valid, input read_data, input irq_lines, output ready);
endinterface

FILE: rtl/tmr_chan.sv
// One counter: its registers, prescaler, count update and register access.
module tmr_chan #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tmr_pkg::tmr_req_t         req,
  input  logic [tmr_pkg::DATA_W-1:0] wdata,
  output logic [tmr_pkg::DATA_W-1:0] rdata,
  output logic                      irq
);
  import tmr_pkg::*;

  logic [CLK_W-1:0]       clk_ctl_r, clk_ctl_nxt;
  logic [CTL_W-1:0]       ctl_r, ctl_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [COUNT_WIDTH-1:0] ival_r, ival_nxt;
  logic [COUNT_WIDTH-1:0] match_r [NUM_MATCH];
  logic [COUNT_WIDTH-1:0] match_nxt [NUM_MATCH];
  logic [STS_W-1:0]       sts_r, sts_nxt;
  logic [STS_W-1:0]       ien_r, ien_nxt;
  logic [PSC_W-1:0]       psc_r, psc_nxt;
  logic [PSC_W-1:0]       limit;
  logic                   adv;

  assign limit = {PSC_W{1'b1}} >> (4'd15 - clk_ctl_r[CLK_W-1:1]);

  always_comb begin
    clk_ctl_nxt = clk_ctl_r;
    ctl_nxt     = ctl_r;
    cnt_nxt     = cnt_r;
    ival_nxt    = ival_r;
    sts_nxt     = sts_r;
    ien_nxt     = ien_r;
    psc_nxt     = psc_r;
    adv         = 1'b0;
    for (int m = 0; m < NUM_MATCH; m++) begin
      match_nxt[m] = match_r[m];
    end

    if (req.tick && !ctl_r[CTL_DIS_BIT]) begin
      if (!clk_ctl_r[CLK_PSC_EN_BIT]) begin
        adv = 1'b1;
      end else if (psc_r >= limit) begin
        psc_nxt = '0;
        adv     = 1'b1;
      end else begin
        psc_nxt = psc_r + 1'b1;
      end
    end

    if (adv) begin
      if (ctl_r[CTL_INT_BIT] && cnt_r == ival_r) begin
        cnt_nxt              = '0;
        sts_nxt[STS_INT_BIT] = 1'b1;
      end else if (cnt_r == {COUNT_WIDTH{1'b1}}) begin
        cnt_nxt              = '0;
        sts_nxt[STS_OVF_BIT] = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end

    if (req.rd && req.grp[GRP_STATUS]) begin
      sts_nxt = '0;
    end

    if (req.wr) begin
      if (req.grp[GRP_CLK_CTL]) begin
        clk_ctl_nxt = wdata[CLK_W-1:0];
      end
      if (req.grp[GRP_CNT_CTL]) begin
        if (wdata[CTL_STROBE_BIT]) begin
          cnt_nxt = '0;
          psc_nxt = '0;
        end
        ctl_nxt = wdata[CTL_W-1:0] & CTL_STORE_MASK;
      end
      if (req.grp[GRP_INTERVAL]) begin
        ival_nxt = wdata[COUNT_WIDTH-1:0];
      end
      for (int m = 0; m < NUM_MATCH; m++) begin
        if (req.grp[GRP_MATCH0+m]) begin
          match_nxt[m] = wdata[COUNT_WIDTH-1:0];
        end
      end
      if (req.grp[GRP_IRQ_EN]) begin
        ien_nxt = wdata[STS_W-1:0];
      end
    end
  end

  always_comb begin
    rdata = '0;
    if (req.rd) begin
      if (req.grp[GRP_CLK_CTL])  rdata = DATA_W'(clk_ctl_r);
      if (req.grp[GRP_CNT_CTL])  rdata = DATA_W'(ctl_r);
      if (req.grp[GRP_COUNT])    rdata = DATA_W'(cnt_r);
      if (req.grp[GRP_INTERVAL]) rdata = DATA_W'(ival_r);
      for (int m = 0; m < NUM_MATCH; m++) begin
        if (req.grp[GRP_MATCH0+m]) rdata = DATA_W'(match_r[m]);
      end
      if (req.grp[GRP_STATUS])   rdata = DATA_W'(sts_r);
      if (req.grp[GRP_IRQ_EN])   rdata = DATA_W'(ien_r);
    end
  end

  assign irq = |(sts_nxt & ien_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_ctl_r <= '0;
      ctl_r     <= CTL_RESET_VALUE;
      cnt_r     <= '0;
      ival_r    <= '0;
      sts_r     <= '0;
      ien_r     <= '0;
      psc_r     <= '0;
      for (int m = 0; m < NUM_MATCH; m++) begin
        match_r[m] <= '0;
      end
    end else begin
      clk_ctl_r <= clk_ctl_nxt;
      ctl_r     <= ctl_nxt;
      cnt_r     <= cnt_nxt;
      ival_r    <= ival_nxt;
      sts_r     <= sts_nxt;
      ien_r     <= ien_nxt;
      psc_r     <= psc_nxt;
      for (int m = 0; m < NUM_MATCH; m++) begin
        match_r[m] <= match_nxt[m];
      end
    end
  end

endmodule

FILE: rtl/triple_interval_timer_counter.sv
// Triple interval timer: takes one item per cycle (tick, register read or
// register write) while the result register is not stalled and returns one
// result per item; an item is registered in the input register and its result
// then in the result register, so results trail items by these two registers;
// a stalled result register holds one item back in the input register before
// the input side stops. Registers sit at word index
// group * NUM_COUNTERS + counter.
module triple_interval_timer_counter #(
  parameter int NUM_COUNTERS = 3,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  tmr_in_if.sink    in_if,
  tmr_out_if.source out_if
);
  import tmr_pkg::*;

  logic              s1_valid_r;
  logic [OP_W-1:0]   s1_op_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic [DATA_W-1:0] s1_data_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_rdata_r;
  logic [IRQ_W-1:0]  out_irq_r;

  logic              s2_adv;
  logic              s2_go;
  logic              in_acc;
  tmr_req_t          req     [NUM_COUNTERS];
  logic [DATA_W-1:0] ch_rdata[NUM_COUNTERS];
  logic              ch_irq  [NUM_COUNTERS];
  logic [DATA_W-1:0] rdata_all;
  logic [IRQ_W-1:0]  irq_all;

  assign s2_adv       = !out_valid_r || out_if.ready;
  assign s2_go        = s1_valid_r && s2_adv;
  assign in_if.ready  = !s1_valid_r || s2_adv;
  assign in_acc       = in_if.valid && in_if.ready;

  assign out_if.valid     = out_valid_r;
  assign out_if.read_data = out_rdata_r;
  assign out_if.irq_lines = out_irq_r;

  for (genvar c = 0; c < NUM_COUNTERS; c++) begin : g_chan
    always_comb begin
      req[c].tick = s2_go && (s1_op_r == OP_TICK);
      req[c].rd   = s2_go && (s1_op_r == OP_READ);
      req[c].wr   = s2_go && (s1_op_r == OP_WRITE);
      for (int g = 0; g < NUM_DEC_GRP; g++) begin
        req[c].grp[g] = (int'(s1_idx_r) == g * NUM_COUNTERS + c);
      end
    end

    tmr_chan #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_chan (
      .clk   (clk),
      .rst_n (rst_n),
      .req   (req[c]),
      .wdata (s1_data_r),
      .rdata (ch_rdata[c]),
      .irq   (ch_irq[c])
    );
  end

  always_comb begin
    rdata_all = '0;
    irq_all   = '0;
    for (int c = 0; c < NUM_COUNTERS; c++) begin
      rdata_all = rdata_all | ch_rdata[c];
      if (c < IRQ_W) begin
        irq_all[c] = ch_irq[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s2_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_go) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= in_if.op;
      s1_idx_r  <= in_if.word_index;
      s1_data_r <= in_if.write_data;
    end
    if (s2_go) begin
      out_rdata_r <= rdata_all;
      out_irq_r   <= irq_all;
    end
  end

endmodule

FILE: rtl/tmr_checker.sv
// Port checker for the triple interval timer and its bind.
`include "assert_macros.svh"

module tmr_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [tmr_pkg::DATA_W-1:0] out_read_data,
  input logic [tmr_pkg::IRQ_W-1:0]  out_irq_lines
);

  `TMR_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `TMR_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_read_data) && $stable(out_irq_lines), "result changed while stalled")
  `TMR_ASSERT(a_stall_cause, clk, rst_n, !in_ready |-> out_valid && !out_ready, "input stalled without a waiting result")
  `TMR_ASSERT_ALWAYS(a_rst_clear, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind triple_interval_timer_counter tmr_checker u_tmr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_read_data (out_if.read_data),
  .out_irq_lines (out_if.irq_lines)
);
